>>> rtl/ring_buffer_deque_defines.svh
// Assertion macros for the deque top level.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQ_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/dq_pkg.sv
// Shared constants, word types and pointer helpers for the deque.
package dq_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes.
  localparam logic [1:0] OP_PUSH_LEFT  = 2'd0;
  localparam logic [1:0] OP_PUSH_RIGHT = 2'd1;
  localparam logic [1:0] OP_POP_LEFT   = 2'd2;
  localparam logic [1:0] OP_POP_RIGHT  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
  } dq_out_t;

  // Advance a pointer by one, wrapping at the capacity.
  function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] p,
                                                input logic [OCC_W-1:0]  cap);
    logic [OCC_W-1:0] inc;
    inc = OCC_W'(p) + OCC_W'(1);
    return (inc >= cap) ? '0 : ADDR_W'(inc);
  endfunction

  // Step a pointer back by one, wrapping to the top slot in use.
  function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] p,
                                                  input logic [OCC_W-1:0]  cap);
    logic [OCC_W-1:0] top;
    top = cap - OCC_W'(1);
    return (p == '0) ? ADDR_W'(top) : p - ADDR_W'(1);
  endfunction

endpackage

>>> rtl/dq_ram.sv
// Single-port synchronous RAM with a registered read port.
module dq_ram #(
  parameter int DEPTH_P = 64,
  parameter int WIDTH_P = 32,
  parameter int AW_P    = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [AW_P-1:0]    addr,
  input  logic [WIDTH_P-1:0] wdata,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];
  logic [WIDTH_P-1:0] rdata_r;

  // Write and read share the one port; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ring_buffer_deque.sv
// Top level of the double-ended queue: control, pointers and result register.
//
// Input channel (in_valid, in_stall, in_word): each word carries an operation
// (push left, push right, pop left, pop right) and a value for pushes. The
// result channel (out_valid, out_stall, out_word) returns exactly one word per
// operation, in order, with a status (done, full or empty) and the value
// pushed or popped, zero when refused.
// A push or a refused operation has its result in the output register in the
// cycle after acceptance, and such operations can be taken every cycle while
// out_stall does not hold the output. A successful pop reads the slot store,
// whose read port is registered; the input stalls during the read cycle.
// The output register parts the two sides: a new word is taken while the
// current result is being delivered, but not while an undelivered result
// is held and out_stall is high.
// cfg_wr_en/cfg_wr_data set the capacity in use (reset 64). Zero counts as
// one and values above the store depth count as the depth. Write it only
// while the block is idle.
// rst_n is synchronous: it empties the queue, clears both pointers and drops
// out_valid. The slot store itself is not cleared and needs no sweep.
module ring_buffer_deque
  import dq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dq_in_t           in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output dq_out_t          out_word,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  `include "ring_buffer_deque_defines.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [ADDR_W-1:0] rear_r, rear_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r, out_valid_nxt;
  dq_out_t           out_word_r, out_word_nxt;

  logic              accept;
  logic [OCC_W-1:0]  cap_eff;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_rdata;

  // Effective capacity: zero counts as one, large values saturate.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = OCC_W'(1);
    end else if (32'(cap_r) > DEPTH) begin
      cap_eff = OCC_W'(DEPTH);
    end else begin
      cap_eff = OCC_W'(cap_r);
    end
  end

  // Take a word only when idle and the output register is free or draining.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Operation decode, pointer update and slot access.
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    occ_nxt       = occ_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;

    if (state_r == ST_READ) begin
      out_valid_nxt       = 1'b1;
      out_word_nxt.status = STATUS_OK;
      out_word_nxt.data   = mem_rdata;
      state_nxt           = ST_IDLE;
    end else if (accept) begin
      if (in_word.operation inside {OP_PUSH_LEFT, OP_PUSH_RIGHT}) begin
        out_valid_nxt = 1'b1;
        if (occ_r >= cap_eff) begin
          out_word_nxt.status = STATUS_FULL;
          out_word_nxt.data   = '0;
        end else begin
          if (occ_r == '0) begin
            front_nxt = '0;
            rear_nxt  = '0;
            mem_addr  = '0;
          end else if (in_word.operation == OP_PUSH_LEFT) begin
            front_nxt = step_down(front_r, cap_eff);
            mem_addr  = front_nxt;
          end else begin
            rear_nxt = step_up(rear_r, cap_eff);
            mem_addr = rear_nxt;
          end
          mem_we              = 1'b1;
          occ_nxt             = occ_r + OCC_W'(1);
          out_word_nxt.status = STATUS_OK;
          out_word_nxt.data   = in_word.push_value;
        end
      end else if (occ_r == '0) begin
        out_valid_nxt       = 1'b1;
        out_word_nxt.status = STATUS_EMPTY;
        out_word_nxt.data   = '0;
      end else begin
        mem_re    = 1'b1;
        occ_nxt   = occ_r - OCC_W'(1);
        state_nxt = ST_READ;
        if (in_word.operation == OP_POP_LEFT) begin
          mem_addr = front_r;
          if (occ_nxt != '0) begin
            front_nxt = step_up(front_r, cap_eff);
          end
        end else begin
          mem_addr = rear_r;
          if (occ_nxt != '0) begin
            rear_nxt = step_down(rear_r, cap_eff);
          end
        end
      end
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      rear_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Slot store.
  dq_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (in_word.push_value),
    .rdata (mem_rdata)
  );

  `DQ_ASSERT_NOW(a_occ_bound, 1'b1, 32'(occ_r) <= DEPTH, "occupancy above store depth")
  `DQ_ASSERT_NOW(a_read_out_free, state_r == ST_READ, !out_valid_r,
                 "result register busy during read")
  `DQ_ASSERT_NOW(a_read_stalls, state_r == ST_READ, in_stall,
                 "input taken during read cycle")
  `DQ_ASSERT_NEXT(a_pop_reads,
                  accept && (in_word.operation == OP_POP_LEFT ||
                             in_word.operation == OP_POP_RIGHT) && occ_r != '0,
                  state_r == ST_READ, "pop did not start a read")
  `DQ_ASSERT_NOW(a_no_access_clash, 1'b1, !(mem_we && mem_re),
                 "store written and read together")

endmodule
